// ===== rtl/core/ray_triangle_intersect_unit_assert.svh =====
// Assertion macros for the ray/triangle intersection unit
`ifndef RAY_TRIANGLE_INTERSECT_UNIT_ASSERT_SVH
`define RAY_TRIANGLE_INTERSECT_UNIT_ASSERT_SVH

// Check that a condition implies a consequence in the same cycle
`define RTI_ASSERT_NOW(label, clk_s, rstn_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("rti assertion failed");

// Check that a condition implies a consequence in the following cycle
`define RTI_ASSERT_NEXT(label, clk_s, rstn_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("rti assertion failed");

`endif

// ===== rtl/core/rti_pkg.sv =====
// Types, widths and helpers shared by the ray/triangle intersection unit
package rti_pkg;

  localparam int CW    = 16;          // input coordinate width
  localparam int OW    = 24;          // output coordinate width
  localparam int TFRAC = 16;          // fraction bits of t_threshold
  localparam int QB    = 40;          // offset clamp exponent, one quotient bit per stage
  localparam int DTW   = 24;          // det_threshold width
  localparam int TTW   = 16;          // t_threshold width
  localparam int CFGW  = 24;          // config data width
  localparam int IDXW  = 2;           // config index width

  localparam int EW    = CW + 1;      // edge / offset vector width
  localparam int PPW   = 2 * CW + 1;  // pvec partial products
  localparam int QPW   = 2 * CW + 2;  // qvec partial products
  localparam int PVW   = 2 * CW + 2;  // pvec
  localparam int QVW   = 2 * CW + 3;  // qvec
  localparam int PW    = 3 * CW + 6;  // determinant and numerators, signed
  localparam int DW    = PW;          // magnitudes after sign fold
  localparam int NUMW  = DW + CW + 2; // rounded division numerator
  localparam int DVW   = DW + 1;      // divisor (2*det)
  localparam int REMW  = DW + 1;      // divider remainder
  localparam int SW    = QB + 3;      // hit point sum width

  localparam int PRE_STAGES = 8;
  localparam int LATENCY    = PRE_STAGES + QB + 1;

  localparam logic signed [SW-1:0] OUT_MAX = SW'((64'sd1 <<< (OW - 1)) - 64'sd1);
  localparam logic signed [SW-1:0] OUT_MIN = -OUT_MAX - SW'(1);

  localparam logic [IDXW-1:0] REG_DET_THRESHOLD = IDXW'(0);
  localparam logic [IDXW-1:0] REG_T_THRESHOLD   = IDXW'(1);

  typedef logic signed [CW-1:0] crd_t;

  typedef struct packed {
    logic [47:0] ray_origin;
    logic [47:0] ray_dir;
    logic [47:0] vertex_a;
    logic [47:0] vertex_b;
    logic [47:0] vertex_c;
  } in_item_t;

  typedef struct packed {
    logic                 hit;
    logic signed [OW-1:0] hit_x;
    logic signed [OW-1:0] hit_y;
    logic signed [OW-1:0] hit_z;
    logic                 saturated;
  } out_result_t;

  // Data that rides along the divider
  typedef struct packed {
    logic            hit;
    logic [2:0][CW-1:0] org;
    logic [2:0]      dneg;
    logic [2:0]      ovf;
  } side_t;

  // Extract coordinate i; slices past bit 47 read as zero
  function automatic crd_t coord(input logic [47:0] p, input int i);
    logic [63:0] e;
    e = {16'b0, p};
    return crd_t'(e[i*CW +: CW]);
  endfunction

endpackage

// ===== rtl/core/rti_div.sv =====
// Pipelined restoring divider, three lanes, one quotient bit per stage
module rti_div
  import rti_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  side_t               in_side,
  input  logic [DVW-1:0]      in_dv,
  input  logic [2:0][REMW-1:0] in_rem,
  input  logic [2:0][QB-1:0]  in_low,
  output logic                out_valid,
  output side_t               out_side,
  output logic [2:0][QB-1:0]  out_q
);

  logic [QB-1:0]             v_r;
  side_t                     side_r [QB];
  logic [DVW-1:0]            dv_r   [QB];
  logic [2:0][REMW-1:0]      rem_r  [QB];
  logic [2:0][QB-1:0]        lq_r   [QB];
  logic [2:0][REMW-1:0]      rem_nxt [QB];
  logic [2:0][QB-1:0]        lq_nxt  [QB];

  // Shift in one numerator bit, trial subtract, and shift the quotient bit into the low word
  always_comb begin
    logic [DVW-1:0]       dv;
    logic [2:0][REMW-1:0] rs;
    logic [2:0][QB-1:0]   ls;
    logic [REMW:0]        r2;
    for (int k = 0; k < QB; k++) begin
      dv = (k == 0) ? in_dv  : dv_r[k-1];
      rs = (k == 0) ? in_rem : rem_r[k-1];
      ls = (k == 0) ? in_low : lq_r[k-1];
      for (int l = 0; l < 3; l++) begin
        r2 = {rs[l], ls[l][QB-1]};
        if (r2 >= (REMW+1)'(dv)) begin
          rem_nxt[k][l] = REMW'(r2 - (REMW+1)'(dv));
          lq_nxt[k][l]  = {ls[l][QB-2:0], 1'b1};
        end else begin
          rem_nxt[k][l] = REMW'(r2);
          lq_nxt[k][l]  = {ls[l][QB-2:0], 1'b0};
        end
      end
    end
  end

  // Advance the valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[QB-2:0], in_valid};
    end
  end

  // Advance the payload
  always_ff @(posedge clk) begin
    for (int k = 0; k < QB; k++) begin
      side_r[k] <= (k == 0) ? in_side : side_r[k-1];
      dv_r[k]   <= (k == 0) ? in_dv   : dv_r[k-1];
      rem_r[k]  <= rem_nxt[k];
      lq_r[k]   <= lq_nxt[k];
    end
  end

  assign out_valid = v_r[QB-1];
  assign out_side  = side_r[QB-1];
  assign out_q     = lq_r[QB-1];

endmodule

// ===== rtl/core/ray_triangle_intersect_unit.sv =====
// Top level of the ray/triangle intersection unit
// One ray/triangle test is accepted every clock (busy stays low). Its
// result is shown on out_result with out_valid high for one cycle. The
// pipeline holds 8 stages of vector, determinant and test arithmetic,
// 40 stages of a restoring divider (one quotient bit each, three lanes),
// and one output stage for the add and clamp. The receiver cannot stall;
// results must be taken in the cycle they are shown. Write thresholds
// only while idle.
module ray_triangle_intersect_unit
  import rti_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  in_item_t          in_item,
  output logic              out_valid,
  output out_result_t       out_result,
  input  logic              cfg_we,
  input  logic [IDXW-1:0]   cfg_index,
  input  logic [CFGW-1:0]   cfg_wdata
);

  logic in_fire;
  assign busy    = 1'b0;
  assign in_fire = start && !busy;

  // Configuration registers
  logic [DTW-1:0] det_thr_r;
  logic [TTW-1:0] t_thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      det_thr_r <= DTW'(16);
      t_thr_r   <= TTW'(16);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DET_THRESHOLD: det_thr_r <= cfg_wdata[DTW-1:0];
        REG_T_THRESHOLD:   t_thr_r   <= cfg_wdata[TTW-1:0];
        default: ;
      endcase
    end
  end

  logic [PRE_STAGES-1:0] v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[PRE_STAGES-2:0], in_fire};
    end
  end

  // Stage 1: unpack and form edges
  crd_t                   o1_r [3], d1_r [3];
  logic signed [EW-1:0]   ab1_r [3], ac1_r [3], tv1_r [3];

  always_ff @(posedge clk) begin
    crd_t a;
    for (int i = 0; i < 3; i++) begin
      a        = coord(in_item.vertex_a, i);
      o1_r[i]  <= coord(in_item.ray_origin, i);
      d1_r[i]  <= coord(in_item.ray_dir, i);
      ab1_r[i] <= EW'(coord(in_item.vertex_b, i)) - EW'(a);
      ac1_r[i] <= EW'(coord(in_item.vertex_c, i)) - EW'(a);
      tv1_r[i] <= EW'(coord(in_item.ray_origin, i)) - EW'(a);
    end
  end

  // Stage 2: cross product partial products
  crd_t                   o2_r [3], d2_r [3];
  logic signed [EW-1:0]   ab2_r [3], ac2_r [3], tv2_r [3];
  logic signed [PPW-1:0]  pp_r [3][2];
  logic signed [QPW-1:0]  qp_r [3][2];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      o2_r[i]     <= o1_r[i];
      d2_r[i]     <= d1_r[i];
      ab2_r[i]    <= ab1_r[i];
      ac2_r[i]    <= ac1_r[i];
      tv2_r[i]    <= tv1_r[i];
      pp_r[i][0]  <= PPW'(d1_r[(i+1)%3]) * PPW'(ac1_r[(i+2)%3]);
      pp_r[i][1]  <= PPW'(d1_r[(i+2)%3]) * PPW'(ac1_r[(i+1)%3]);
      qp_r[i][0]  <= QPW'(tv1_r[(i+1)%3]) * QPW'(ab1_r[(i+2)%3]);
      qp_r[i][1]  <= QPW'(tv1_r[(i+2)%3]) * QPW'(ab1_r[(i+1)%3]);
    end
  end

  // Stage 3: pvec and qvec
  crd_t                   o3_r [3], d3_r [3];
  logic signed [EW-1:0]   ab3_r [3], ac3_r [3], tv3_r [3];
  logic signed [PVW-1:0]  pv_r [3];
  logic signed [QVW-1:0]  qv_r [3];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      o3_r[i]  <= o2_r[i];
      d3_r[i]  <= d2_r[i];
      ab3_r[i] <= ab2_r[i];
      ac3_r[i] <= ac2_r[i];
      tv3_r[i] <= tv2_r[i];
      pv_r[i]  <= PVW'(pp_r[i][0]) - PVW'(pp_r[i][1]);
      qv_r[i]  <= QVW'(qp_r[i][0]) - QVW'(qp_r[i][1]);
    end
  end

  // Stage 4: dot product terms
  crd_t                  o4_r [3], d4_r [3];
  logic signed [PW-1:0]  mdet_r [3], mu_r [3], mv_r [3], mt_r [3];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      o4_r[i]   <= o3_r[i];
      d4_r[i]   <= d3_r[i];
      mdet_r[i] <= PW'(ab3_r[i]) * PW'(pv_r[i]);
      mu_r[i]   <= PW'(tv3_r[i]) * PW'(pv_r[i]);
      mv_r[i]   <= PW'(d3_r[i])  * PW'(qv_r[i]);
      mt_r[i]   <= PW'(ac3_r[i]) * PW'(qv_r[i]);
    end
  end

  // Stage 5: sum into det, U, V, T
  crd_t                  o5_r [3], d5_r [3];
  logic signed [PW-1:0]  det5_r, u5_r, v5_r, t5_r;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      o5_r[i] <= o4_r[i];
      d5_r[i] <= d4_r[i];
    end
    det5_r <= mdet_r[0] + mdet_r[1] + mdet_r[2];
    u5_r   <= mu_r[0] + mu_r[1] + mu_r[2];
    v5_r   <= mv_r[0] + mv_r[1] + mv_r[2];
    t5_r   <= mt_r[0] + mt_r[1] + mt_r[2];
  end

  // Stage 6: fold the sign so det is non-negative; split direction into sign and magnitude
  crd_t                  o6_r [3];
  logic [CW-1:0]         dmag6_r [3];
  logic [2:0]            dneg6_r;
  logic signed [PW-1:0]  det6_r, u6_r, v6_r, t6_r;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      o6_r[i]    <= o5_r[i];
      dneg6_r[i] <= d5_r[i][CW-1];
      dmag6_r[i] <= d5_r[i][CW-1] ? CW'(-d5_r[i]) : CW'(d5_r[i]);
    end
    if (det5_r[PW-1]) begin
      det6_r <= -det5_r;
      u6_r   <= -u5_r;
      v6_r   <= -v5_r;
      t6_r   <= -t5_r;
    end else begin
      det6_r <= det5_r;
      u6_r   <= u5_r;
      v6_r   <= v5_r;
      t6_r   <= t5_r;
    end
  end

  // Stage 7: barycentric tests and the products for the t test and offsets
  crd_t                   o7_r [3];
  logic [2:0]             dneg7_r;
  logic                   hitp7_r;
  logic [DW-1:0]          det7_r;
  logic [DW+TTW-1:0]      pt7_r;
  logic [DW+TFRAC-1:0]    ts7_r;
  logic [DW+CW-1:0]       tdm7_r [3];

  always_ff @(posedge clk) begin
    logic signed [PW:0] uv;
    logic               det_ok, uv_ok;
    uv     = (PW+1)'(u6_r) + (PW+1)'(v6_r);
    det_ok = (det6_r != '0) && (DW'(det6_r) >= DW'(det_thr_r));
    uv_ok  = !u6_r[PW-1] && (u6_r <= det6_r) && !v6_r[PW-1] && (uv <= (PW+1)'(det6_r));
    hitp7_r <= det_ok && uv_ok && !t6_r[PW-1];
    det7_r  <= DW'(det6_r);
    pt7_r   <= (DW+TTW)'(DW'(det6_r)) * (DW+TTW)'(t_thr_r);
    ts7_r   <= {DW'(t6_r), TFRAC'(0)};
    dneg7_r <= dneg6_r;
    for (int i = 0; i < 3; i++) begin
      o7_r[i]   <= o6_r[i];
      tdm7_r[i] <= (DW+CW)'(DW'(t6_r)) * (DW+CW)'(dmag6_r[i]);
    end
  end

  // Stage 8: t test, rounded numerator, clamp detect and divider seed
  side_t                 side8_r;
  logic [DVW-1:0]        dv8_r;
  logic [2:0][REMW-1:0]  rem8_r;
  logic [2:0][QB-1:0]    low8_r;

  always_ff @(posedge clk) begin
    logic [NUMW-1:0]    num;
    logic [NUMW+QB-1:0] numx;
    logic [DVW-1:0]     dv;
    dv = {det7_r, 1'b0};
    side8_r.hit  <= hitp7_r && (DW+TFRAC+TTW)'(pt7_r) < (DW+TFRAC+TTW)'(ts7_r);
    side8_r.dneg <= dneg7_r;
    dv8_r        <= dv;
    for (int i = 0; i < 3; i++) begin
      num  = {tdm7_r[i], 1'b0} + NUMW'(det7_r);
      numx = (NUMW+QB)'(num);
      side8_r.org[i] <= o7_r[i];
      side8_r.ovf[i] <= (numx >> QB) >= (NUMW+QB)'(dv);
      rem8_r[i]      <= REMW'(numx >> QB);
      low8_r[i]      <= numx[QB-1:0];
    end
  end

  // Stages 9 to 48: offset quotients
  logic               div_valid;
  side_t              div_side;
  logic [2:0][QB-1:0] div_q;

  rti_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v_r[PRE_STAGES-1]),
    .in_side   (side8_r),
    .in_dv     (dv8_r),
    .in_rem    (rem8_r),
    .in_low    (low8_r),
    .out_valid (div_valid),
    .out_side  (div_side),
    .out_q     (div_q)
  );

  // Output stage: add offsets to origin and clamp
  logic        out_valid_r;
  out_result_t out_result_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    logic [QB:0]          qm;
    logic signed [SW-1:0] p;
    logic [2:0]           sat;
    logic signed [OW-1:0] pc [3];
    for (int i = 0; i < 3; i++) begin
      qm = div_side.ovf[i] ? (QB+1)'(1) << QB : {1'b0, div_q[i]};
      p  = SW'(signed'(div_side.org[i]));
      p  = div_side.dneg[i] ? p - SW'(qm) : p + SW'(qm);
      sat[i] = 1'b0;
      if (p > OUT_MAX) begin
        p      = OUT_MAX;
        sat[i] = 1'b1;
      end else if (p < OUT_MIN) begin
        p      = OUT_MIN;
        sat[i] = 1'b1;
      end
      pc[i] = div_side.hit ? OW'(p) : '0;
    end
    out_result_r.hit       <= div_side.hit;
    out_result_r.hit_x     <= pc[0];
    out_result_r.hit_y     <= pc[1];
    out_result_r.hit_z     <= pc[2];
    out_result_r.saturated <= div_side.hit && (sat != 3'b000);
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

`include "ray_triangle_intersect_unit_assert.svh"

  `RTI_ASSERT_NOW(a_miss_zero, clk, rst_n, out_valid && !out_result.hit, (out_result.hit_x == '0 && out_result.hit_y == '0 && out_result.hit_z == '0 && !out_result.saturated))
  `RTI_ASSERT_NOW(a_sat_hit, clk, rst_n, out_valid && out_result.saturated, out_result.hit)
  `RTI_ASSERT_NOW(a_latency, clk, rst_n, out_valid, $past(in_fire, LATENCY))
  `RTI_ASSERT_NEXT(a_div_out, clk, rst_n, div_valid, out_valid)

endmodule

// ===== bench/ray_triangle_intersect_checker.sv =====
// Checker for the ray/triangle intersection unit: predicts and compares results
`timescale 1ns / 1ps

module ray_triangle_intersect_checker
  import rti_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic            busy,
  input  in_item_t        in_item,
  input  logic            out_valid,
  input  out_result_t     out_result,
  input  logic            cfg_we,
  input  logic [IDXW-1:0] cfg_index,
  input  logic [CFGW-1:0] cfg_wdata,
  output int              fail_count,
  output int              pending_count
);

  typedef logic signed [127:0] wide_t;

  logic [DTW-1:0] det_limit;
  logic [TTW-1:0] t_limit;
  out_result_t    hit_queue[$];

  // Work out the hit/miss result and hit point of one transaction at the given thresholds
  function automatic out_result_t predict_intersection(in_item_t it, logic [DTW-1:0] dthr,
                                                       logic [TTW-1:0] tthr);
    wide_t o[3], d[3], ab[3], ac[3], tv[3], pv[3], qv[3];
    wide_t det, u, v, t, a, q, p, dlim, tlim, dmag;
    logic  ok, sat;
    out_result_t r;
    for (int i = 0; i < 3; i++) begin
      a     = $signed(it.vertex_a[i*CW +: CW]);
      o[i]  = $signed(it.ray_origin[i*CW +: CW]);
      d[i]  = $signed(it.ray_dir[i*CW +: CW]);
      ab[i] = wide_t'($signed(it.vertex_b[i*CW +: CW])) - a;
      ac[i] = wide_t'($signed(it.vertex_c[i*CW +: CW])) - a;
      tv[i] = o[i] - a;
    end
    pv[0] = d[1] * ac[2] - d[2] * ac[1];
    pv[1] = d[2] * ac[0] - d[0] * ac[2];
    pv[2] = d[0] * ac[1] - d[1] * ac[0];
    qv[0] = tv[1] * ab[2] - tv[2] * ab[1];
    qv[1] = tv[2] * ab[0] - tv[0] * ab[2];
    qv[2] = tv[0] * ab[1] - tv[1] * ab[0];
    det = ab[0] * pv[0] + ab[1] * pv[1] + ab[2] * pv[2];
    u   = tv[0] * pv[0] + tv[1] * pv[1] + tv[2] * pv[2];
    v   = d[0] * qv[0] + d[1] * qv[1] + d[2] * qv[2];
    t   = ac[0] * qv[0] + ac[1] * qv[1] + ac[2] * qv[2];
    // fold the sign so that all tests run with a non-negative determinant
    if (det < 0) begin
      det = -det; u = -u; v = -v; t = -t;
    end
    dlim = {104'b0, dthr};
    tlim = {112'b0, tthr};
    ok = (det != 0) && (det >= dlim) && (u >= 0) && (u <= det) && (v >= 0) &&
         (u + v <= det) && (t >= 0) && (det * tlim < (t <<< TFRAC));
    r   = '0;
    sat = 1'b0;
    if (ok) begin
      r.hit = 1'b1;
      for (int i = 0; i < 3; i++) begin
        dmag = (d[i] < 0) ? -d[i] : d[i];
        q = (2 * t * dmag + det) / (2 * det);
        if (q > (wide_t'(1) <<< QB)) q = wide_t'(1) <<< QB;
        p = o[i] + ((d[i] < 0) ? -q : q);
        if (p > wide_t'(OUT_MAX)) begin
          p = wide_t'(OUT_MAX); sat = 1'b1;
        end
        if (p < wide_t'(OUT_MIN)) begin
          p = wide_t'(OUT_MIN); sat = 1'b1;
        end
        case (i)
          0: r.hit_x = p[OW-1:0];
          1: r.hit_y = p[OW-1:0];
          default: r.hit_z = p[OW-1:0];
        endcase
      end
      r.saturated = sat;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    fail_count++;
  endtask

  assign pending_count = hit_queue.size();

  // Track thresholds, queue predictions and compare results
  always @(posedge clk) begin
    out_result_t want;
    if (!rst_n) begin
      det_limit = DTW'(16);
      t_limit   = TTW'(16);
      hit_queue.delete();
    end else begin
      if (out_valid) begin
        if (hit_queue.size() == 0) begin
          report_mismatch("unexpected result", 64'(out_result.hit), 64'(0));
        end else begin
          want = hit_queue.pop_front();
          if (out_result.hit != want.hit)
            report_mismatch("hit", 64'(out_result.hit), 64'(want.hit));
          if (out_result.hit_x != want.hit_x)
            report_mismatch("hit_x", 64'(out_result.hit_x), 64'(want.hit_x));
          if (out_result.hit_y != want.hit_y)
            report_mismatch("hit_y", 64'(out_result.hit_y), 64'(want.hit_y));
          if (out_result.hit_z != want.hit_z)
            report_mismatch("hit_z", 64'(out_result.hit_z), 64'(want.hit_z));
          if (out_result.saturated != want.saturated)
            report_mismatch("saturated", 64'(out_result.saturated), 64'(want.saturated));
        end
      end
      if (start && !busy) hit_queue.push_back(predict_intersection(in_item, det_limit, t_limit));
      if (cfg_we) begin
        if (cfg_index == REG_DET_THRESHOLD) det_limit = cfg_wdata[DTW-1:0];
        else if (cfg_index == REG_T_THRESHOLD) t_limit = cfg_wdata[TTW-1:0];
      end
    end
  end

  initial fail_count = 0;

endmodule

// ===== bench/ray_triangle_intersect_unit_tb.sv =====
// Testbench top for the ray/triangle intersection unit: stimulus and verdict
`timescale 1ns / 1ps

module ray_triangle_intersect_unit_tb
  import rti_pkg::*;
();

  localparam logic [IDXW-1:0] REG_UNUSED = IDXW'(2);
  localparam int RANDOM_ITEMS = 1130;

  logic            clk;
  logic            rst_n;
  logic            start;
  logic            busy;
  in_item_t        in_item;
  logic            out_valid;
  out_result_t     out_result;
  logic            cfg_we;
  logic [IDXW-1:0] cfg_index;
  logic [CFGW-1:0] cfg_wdata;
  int              fail_count;
  int              pending_count;

  ray_triangle_intersect_unit i_dut (.*);

  ray_triangle_intersect_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Pack three Q8.8 coordinates
  function automatic logic [47:0] vec3(int x, int y, int z);
    return {16'(z), 16'(y), 16'(x)};
  endfunction

  // Drive one transaction and hold it until accepted
  task automatic send_test(logic [47:0] o, logic [47:0] d, logic [47:0] a,
                           logic [47:0] b, logic [47:0] c);
    in_item = '{ray_origin: o, ray_dir: d, vertex_a: a, vertex_b: b, vertex_c: c};
    start   = 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
    start = 1'b0;
  endtask

  // Insert a random idle gap: mostly none or short, a few long
  task automatic idle_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return;
    if (pick < 95) repeat ($urandom_range(1, 3)) @(negedge clk);
    else repeat ($urandom_range(10, 60)) @(negedge clk);
  endtask

  // Hold until every expected result is in, then let the pipe drain
  task automatic drain();
    while (pending_count != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  task automatic write_reg(logic [IDXW-1:0] idx, logic [CFGW-1:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Ray aimed inside or just around a random triangle; a quarter aimed away
  task automatic send_aimed();
    int a[3], b[3], c[3], o[3], dd[3], s, r, burst;
    s = $urandom_range(0, 300);
    r = $urandom_range(0, 300 - s);
    for (int i = 0; i < 3; i++) begin
      a[i] = $urandom_range(0, 16000) - 8000;
      b[i] = $urandom_range(0, 16000) - 8000;
      c[i] = $urandom_range(0, 16000) - 8000;
      o[i] = $urandom_range(0, 16000) - 8000;
      dd[i] = a[i] + ((b[i] - a[i]) * (s - 20) + (c[i] - a[i]) * (r - 20)) / 256 - o[i];
      if (dd[i] > 32767) dd[i] = 32767;
      if (dd[i] < -32768) dd[i] = -32768;
    end
    burst = $urandom_range(0, 3);
    for (int i = 0; i < 3; i++) if (burst == 0) dd[i] = -dd[i] / 2;
    send_test(vec3(o[0], o[1], o[2]), vec3(dd[0], dd[1], dd[2]), vec3(a[0], a[1], a[2]),
              vec3(b[0], b[1], b[2]), vec3(c[0], c[1], c[2]));
  endtask

  task automatic send_noise();
    logic [47:0] f[5];
    for (int i = 0; i < 5; i++) f[i] = 48'({$urandom(), $urandom()});
    send_test(f[0], f[1], f[2], f[3], f[4]);
  endtask

  task automatic random_phase(int count);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 99) < 70) send_aimed();
      else send_noise();
      idle_gap();
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    start     = 1'b0;
    in_item   = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: plain hit, parallel ray, swapped winding, outside u, v, u+v, behind origin
    send_test(vec3(64, 64, -256), vec3(0, 0, 256), vec3(0, 0, 0), vec3(256, 0, 0),
              vec3(0, 256, 0));
    send_test(vec3(64, 64, -256), vec3(256, 0, 0), vec3(0, 0, 0), vec3(256, 0, 0),
              vec3(0, 256, 0));
    send_test(vec3(64, 64, -256), vec3(0, 0, 256), vec3(0, 0, 0), vec3(0, 256, 0),
              vec3(256, 0, 0));
    send_test(vec3(-64, 64, -256), vec3(0, 0, 256), vec3(0, 0, 0), vec3(256, 0, 0),
              vec3(0, 256, 0));
    send_test(vec3(64, -64, -256), vec3(0, 0, 256), vec3(0, 0, 0), vec3(256, 0, 0),
              vec3(0, 256, 0));
    send_test(vec3(200, 200, -256), vec3(0, 0, 256), vec3(0, 0, 0), vec3(256, 0, 0),
              vec3(0, 256, 0));
    send_test(vec3(64, 64, 256), vec3(0, 0, 256), vec3(0, 0, 0), vec3(256, 0, 0),
              vec3(0, 256, 0));
    // edge and vertex hits, tiny direction, extreme coordinates
    send_test(vec3(0, 0, -256), vec3(0, 0, 1), vec3(0, 0, 0), vec3(256, 0, 0),
              vec3(0, 256, 0));
    send_test(vec3(128, 128, -256), vec3(0, 0, 256), vec3(0, 0, 0), vec3(256, 0, 0),
              vec3(0, 256, 0));
    send_test(vec3(-32768, -32768, -32768), vec3(32767, 32767, 32767),
              vec3(32767, -32768, 0), vec3(-32768, 32767, 0), vec3(32767, 32767, 32767));
    send_test(vec3(32767, 32767, 32767), vec3(-32768, -32768, -32768),
              vec3(-32768, 0, 0), vec3(0, -32768, 0), vec3(0, 0, -32768));
    send_test(vec3(0, 0, -32768), vec3(1, 1, 32767), vec3(-32768, -32768, 32767),
              vec3(32767, -32768, 32767), vec3(0, 32767, 32767));
    send_test('0, '0, '0, '0, '0);
    send_test('1, '1, '1, '1, '1);
    send_test({3{16'h8000}}, {3{16'h7fff}}, {3{16'h8000}}, {3{16'h7fff}}, {3{16'h0001}});
    random_phase(RANDOM_ITEMS / 5);

    // zero thresholds, also a write to an unused index
    drain();
    write_reg(REG_DET_THRESHOLD, '0);
    write_reg(REG_T_THRESHOLD, '0);
    write_reg(REG_UNUSED, '1);
    send_test(vec3(64, 64, 0), vec3(0, 0, 256), vec3(0, 0, 0), vec3(256, 0, 0),
              vec3(0, 256, 0));
    send_test(vec3(64, 64, -256), vec3(256, 0, 0), vec3(0, 0, 0), vec3(256, 0, 0),
              vec3(0, 256, 0));
    random_phase(RANDOM_ITEMS / 5);

    // maximum thresholds
    drain();
    write_reg(REG_DET_THRESHOLD, '1);
    write_reg(REG_T_THRESHOLD, '1);
    random_phase(RANDOM_ITEMS / 5);

    // random thresholds
    drain();
    write_reg(REG_DET_THRESHOLD, CFGW'($urandom_range(0, 4000)));
    write_reg(REG_T_THRESHOLD, CFGW'($urandom_range(0, 65535)));
    random_phase(RANDOM_ITEMS / 5);

    // back to modest thresholds with a full-width upper byte that must be masked
    drain();
    write_reg(REG_DET_THRESHOLD, 24'd1000);
    write_reg(REG_T_THRESHOLD, 24'hff8000);
    random_phase(RANDOM_ITEMS - 4 * (RANDOM_ITEMS / 5));

    drain();
    if (fail_count == 0 && pending_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/rti_pkg.sv
rtl/core/rti_div.sv
rtl/core/ray_triangle_intersect_unit.sv
bench/ray_triangle_intersect_checker.sv
bench/ray_triangle_intersect_unit_tb.sv
